>>> rtl/core/ssc_pkg.sv
// shared types, constants and lookup tables of the selective state scan
package ssc_pkg;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row;
        logic signed [31:0] load_value;
        logic signed [31:0] x_value;
        logic signed [31:0] dt_value;
        logic signed [31:0] b_value;
        logic signed [31:0] c_value;
        logic               final_row;
    } t_req;

    typedef struct packed {
        logic [3:0]         row_out;
        logic signed [31:0] new_state;
        logic signed [31:0] y_out;
        logic               y_valid;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] state;
        logic signed [31:0] decay;
    } t_cell;

    typedef struct packed {
        logic               we_state;
        logic               we_decay;
        logic signed [31:0] value;
    } t_cell_upd;

    localparam logic [1:0] ACT_LOAD_STATE = 2'd0;
    localparam logic [1:0] ACT_LOAD_DECAY = 2'd1;
    localparam logic [1:0] ACT_STEP       = 2'd2;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic signed [31:0] LN2_Q30   = 32'sd744261118;
    localparam logic signed [31:0] MAX32     = 32'sh7fffffff;

    // 2^(i/16) in q16
    function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // log2(1 + i/16) in q16
    function automatic logic [17:0] log2_tab(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:  v = 18'd0;
            5'd1:  v = 18'd5732;
            5'd2:  v = 18'd11136;
            5'd3:  v = 18'd16248;
            5'd4:  v = 18'd21098;
            5'd5:  v = 18'd25711;
            5'd6:  v = 18'd30109;
            5'd7:  v = 18'd34312;
            5'd8:  v = 18'd38336;
            5'd9:  v = 18'd42196;
            5'd10: v = 18'd45904;
            5'd11: v = 18'd49472;
            5'd12: v = 18'd52911;
            5'd13: v = 18'd56228;
            5'd14: v = 18'd59434;
            5'd15: v = 18'd62534;
            default: v = 18'd65536;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh000000007fffffff) begin
            r = MAX32;
        end else if (v < -64'sh0000000080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        logic signed [39:0] r;
        if (v > 64'sh0000007fffffffff) begin
            r = 40'sh7fffffffff;
        end else if (v < -64'sh0000008000000000) begin
            r = 40'sh8000000000;
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ssc_in_if.sv
// request channel of the selective state scan
interface ssc_in_if
    import ssc_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ssc_out_if.sv
// result channel of the selective state scan
interface ssc_out_if
    import ssc_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ssc_cell.sv
// one cell of the rotating state ring: takes its neighbor's entry each cycle
module ssc_cell
    import ssc_pkg::*;
(
    input  logic      i_clk,
    input  t_cell     i_nbr,
    input  t_cell_upd i_upd,
    output t_cell     o_cur
);
    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = i_nbr;
        if (i_upd.we_state) begin
            n_cell.state = i_upd.value;
        end
        if (i_upd.we_decay) begin
            n_cell.decay = i_upd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cur = r_cell;
endmodule

>>> rtl/core/ssc_mul.sv
// shared signed 32x32 multiplier with registered product
module ssc_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);
    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

>>> rtl/core/selective_state_scan.sv
// top level of the selective state scan: sequencer, shared multiplier, state ring
//
// The block runs the selective state-space recurrence for one channel, one
// request at a time. State and decay entries live in a ring of STATE_ROWS
// cells that rotates by one cell every cycle; a row is read or written when
// it passes the head cell. A load request holds the input through its
// acceptance, the wait for its row and the write. A token step fetches its
// row, then runs its sequencer states on one shared 32x32 multiplier
// (softplus through exp and log tables, decay exp, four products), with the
// softplus tables skipped when dt is above 20, then waits for its row to
// come round again to write back. A step holds the input until the write,
// which also waits for the output register to empty. The result sits in
// that output register, so the next request is taken while it waits. The
// broadcast bit written through i_cfg_we makes every row use decay entry
// zero. Values are signed Q(32-FRAC_BITS).FRAC_BITS and saturate.
module selective_state_scan
    import ssc_pkg::*;
#(
    parameter int STATE_ROWS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    ssc_in_if.sink     i_req,
    ssc_out_if.source  o_rsp
);
    localparam int RW  = $clog2(STATE_ROWS);
    localparam int SEG = FRAC_BITS - 4;
    localparam int QL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int QR  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam logic signed [32:0] TWENTY  = 33'(20) <<< FRAC_BITS;
    localparam logic signed [32:0] LO33    = -(33'(64) <<< FRAC_BITS);
    localparam logic signed [63:0] LO64    = -(64'(64) <<< FRAC_BITS);
    localparam logic signed [63:0] HI64    = 64'(32) <<< FRAC_BITS;
    localparam logic signed [31:0] ONE     = 32'(1) <<< FRAC_BITS;
    localparam logic signed [8:0]  SH_OFF  = 9'(FRAC_BITS - 16);
    localparam logic [RW-1:0]      LAST    = RW'(STATE_ROWS - 1);

    typedef enum logic [18:0] {
        S_IDLE  = 19'(1) << 0,
        S_LOAD  = 19'(1) << 1,
        S_FETCH = 19'(1) << 2,
        S_EX0   = 19'(1) << 3,
        S_EX1   = 19'(1) << 4,
        S_EX2   = 19'(1) << 5,
        S_LG1   = 19'(1) << 6,
        S_LG2   = 19'(1) << 7,
        S_LG3   = 19'(1) << 8,
        S_SPM   = 19'(1) << 9,
        S_SPV   = 19'(1) << 10,
        S_XM    = 19'(1) << 11,
        S_XB    = 19'(1) << 12,
        S_BM    = 19'(1) << 13,
        S_SD    = 19'(1) << 14,
        S_NS    = 19'(1) << 15,
        S_CM    = 19'(1) << 16,
        S_ACC   = 19'(1) << 17,
        S_WB    = 19'(1) << 18
    } t_state;

    t_state             r_state;
    t_req               r_req;
    logic [RW-1:0]      r_pos;
    logic               r_bcast;
    logic signed [31:0] r_dec0;
    logic signed [31:0] r_s;
    logic signed [31:0] r_d;
    logic signed [31:0] r_v;
    logic               r_ret;      // 0: exp for softplus, 1: decay exp
    logic signed [7:0]  r_n;
    logic [3:0]         r_idx;
    logic signed [31:0] r_e;
    logic signed [31:0] r_sp;
    logic signed [31:0] r_dec;
    logic signed [31:0] r_xdt;
    logic signed [63:0] r_p1;
    logic signed [31:0] r_ns;
    logic signed [39:0] r_sum;
    t_rsp               r_rsp;
    logic               r_ovalid;

    t_cell              w_cell [STATE_ROWS];
    t_cell_upd          w_upd;
    t_cell              w_head;
    logic               w_hit;
    logic               w_wb_fire;

    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_prod_f;

    // exp helpers
    logic signed [63:0] w_t;
    logic [FRAC_BITS-1:0] w_frac;
    logic [3:0]         w_tidx;
    logic [SEG-1:0]     w_trr;
    logic signed [63:0] w_m64;
    logic [17:0]        w_m;
    logic signed [8:0]  w_sh;
    logic [8:0]         w_nsh;
    logic [37:0]        w_shl;
    logic signed [31:0] w_exp;

    // softplus helpers
    logic signed [32:0] w_dt33;
    logic signed [32:0] w_nabs;
    logic [3:0]         w_eidx;
    logic [SEG-1:0]     w_err;
    logic signed [63:0] w_l2_64;
    logic signed [31:0] w_l2;
    logic [31:0]        w_ln;
    logic signed [31:0] w_sp_ln;
    logic signed [63:0] w_v2;

    // row ring
    assign w_head = w_cell[0];
    assign w_hit  = (r_pos == RW'(r_req.row));

    genvar gi;
    generate
        for (gi = 0; gi < STATE_ROWS; gi++) begin : g_ring
            if (gi == STATE_ROWS - 1) begin : g_tail
                // the head entry wraps to the tail, with any write applied
                ssc_cell u_cell (
                    .i_clk (i_clk),
                    .i_nbr (w_cell[0]),
                    .i_upd (w_upd),
                    .o_cur (w_cell[gi])
                );
            end else begin : g_body
                ssc_cell u_cell (
                    .i_clk (i_clk),
                    .i_nbr (w_cell[gi+1]),
                    .i_upd ('0),
                    .o_cur (w_cell[gi])
                );
            end
        end
    endgenerate

    assign w_wb_fire = (r_state == S_WB) && w_hit && (!r_ovalid || o_rsp.ready);

    always_comb begin
        w_upd = '0;
        if (r_state == S_LOAD && w_hit) begin
            w_upd.we_state = (r_req.action == ACT_LOAD_STATE);
            w_upd.we_decay = (r_req.action == ACT_LOAD_DECAY);
            w_upd.value    = r_req.load_value;
        end else if (w_wb_fire) begin
            w_upd.we_state = 1'b1;
            w_upd.value    = r_ns;
        end
    end

    // exp: table index, fraction and final shift
    assign w_t    = w_prod >>> 30;
    assign w_frac = w_t[FRAC_BITS-1:0];
    assign w_tidx = w_frac[FRAC_BITS-1 -: 4];
    assign w_trr  = w_frac[SEG-1:0];
    assign w_prod_f = w_prod >>> FRAC_BITS;
    assign w_m64  = $signed({46'd0, exp2_tab({1'b0, r_idx})}) + (w_prod >>> SEG);
    assign w_m    = w_m64[17:0];
    assign w_sh   = {r_n[7], r_n} + SH_OFF;
    assign w_nsh  = 9'(-w_sh);
    assign w_shl  = {20'd0, w_m} << w_sh[4:0];

    always_comb begin
        if (w_sh > 9'sd20) begin
            w_exp = MAX32;
        end else if (w_sh >= 9'sd0) begin
            w_exp = (w_shl[37:31] != 7'd0) ? MAX32 : $signed(w_shl[31:0]);
        end else if (w_sh <= -9'sd40) begin
            w_exp = '0;
        end else begin
            w_exp = $signed({14'd0, w_m} >> w_nsh[5:0]);
        end
    end

    // softplus pieces
    assign w_dt33  = {r_req.dt_value[31], r_req.dt_value};
    assign w_nabs  = r_req.dt_value[31] ? w_dt33 : -w_dt33;
    assign w_eidx  = r_e[FRAC_BITS-1 -: 4];
    assign w_err   = r_e[SEG-1:0];
    assign w_l2_64 = $signed({46'd0, log2_tab({1'b0, r_idx})}) + (w_prod >>> SEG);
    assign w_l2    = (r_e >= ONE) ? 32'sd65536 : w_l2_64[31:0];
    assign w_ln    = ((32'(w_t[16:0])) << QL) >> QR;
    assign w_sp_ln = (r_req.dt_value > 32'sd0 ? r_req.dt_value : 32'sd0) + $signed(w_ln);
    assign w_v2    = (w_prod_f < LO64) ? LO64 : ((w_prod_f > HI64) ? HI64 : w_prod_f);

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_EX0: begin
                w_ma = r_v;
                w_mb = LOG2E_Q30;
            end
            S_EX1: begin
                w_ma = 32'(exp2_tab({1'b0, w_tidx} + 5'd1)) - 32'(exp2_tab({1'b0, w_tidx}));
                w_mb = 32'(w_trr);
            end
            S_LG1: begin
                w_ma = 32'(log2_tab({1'b0, w_eidx} + 5'd1)) - 32'(log2_tab({1'b0, w_eidx}));
                w_mb = 32'(w_err);
            end
            S_LG2: begin
                w_ma = w_l2;
                w_mb = LN2_Q30;
            end
            S_SPM: begin
                w_ma = r_sp;
                w_mb = r_d;
            end
            S_XM: begin
                w_ma = r_req.x_value;
                w_mb = r_sp;
            end
            S_BM: begin
                w_ma = r_req.b_value;
                w_mb = r_xdt;
            end
            S_SD: begin
                w_ma = r_s;
                w_mb = r_dec;
            end
            S_CM: begin
                w_ma = r_ns;
                w_mb = r_req.c_value;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    ssc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // no request is taken while reset is held
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    r_req <= i_req.data;
                end
            end
            S_LOAD: begin
                if (w_hit && r_req.action == ACT_LOAD_DECAY && r_req.row == 4'd0) begin
                    r_dec0 <= r_req.load_value;
                end
            end
            S_FETCH: begin
                r_s   <= w_head.state;
                r_d   <= r_bcast ? r_dec0 : w_head.decay;
                r_ret <= 1'b0;
                r_sp  <= r_req.dt_value;
                r_v   <= (w_nabs < LO33) ? LO33[31:0] : w_nabs[31:0];
            end
            S_EX1: begin
                r_n   <= w_t[FRAC_BITS+7:FRAC_BITS];
                r_idx <= w_tidx;
            end
            S_EX2: begin
                if (r_ret) begin
                    r_dec <= w_exp;
                end else begin
                    r_e <= w_exp;
                end
            end
            S_LG1: r_idx <= w_eidx;
            S_LG3: r_sp  <= w_sp_ln;
            S_SPV: begin
                r_v   <= w_v2[31:0];
                r_ret <= 1'b1;
            end
            S_XB:  r_xdt <= sat32(w_prod_f);
            S_SD:  r_p1  <= w_prod_f;
            S_NS:  r_ns  <= sat32(r_p1 + w_prod_f);
            default: begin
            end
        endcase
        if (w_wb_fire) begin
            r_rsp.row_out   <= r_req.row;
            r_rsp.new_state <= r_ns;
            r_rsp.y_out     <= r_req.final_row ? sat32(64'(r_sum)) : 32'sd0;
            r_rsp.y_valid   <= r_req.final_row;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_bcast  <= 1'b0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pos <= (r_pos == LAST) ? '0 : r_pos + RW'(1);
            if (i_cfg_we) begin
                r_bcast <= i_cfg_data;
            end
            if (w_wb_fire) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.data.action == ACT_STEP) begin
                            r_state <= S_FETCH;
                        end else if (i_req.data.action == ACT_LOAD_STATE ||
                                     i_req.data.action == ACT_LOAD_DECAY) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD:  if (w_hit) r_state <= S_IDLE;
                S_FETCH: begin
                    if (w_hit) begin
                        // large dt skips the softplus tables
                        r_state <= (w_dt33 > TWENTY) ? S_SPM : S_EX0;
                    end
                end
                S_EX0:  r_state <= S_EX1;
                S_EX1:  r_state <= S_EX2;
                S_EX2:  r_state <= r_ret ? S_XM : S_LG1;
                S_LG1:  r_state <= S_LG2;
                S_LG2:  r_state <= S_LG3;
                S_LG3:  r_state <= S_SPM;
                S_SPM:  r_state <= S_SPV;
                S_SPV:  r_state <= S_EX0;
                S_XM:   r_state <= S_XB;
                S_XB:   r_state <= S_BM;
                S_BM:   r_state <= S_SD;
                S_SD:   r_state <= S_NS;
                S_NS:   r_state <= S_CM;
                S_CM:   r_state <= S_ACC;
                S_ACC: begin
                    r_sum   <= sat40(64'(r_sum) + w_prod_f);
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_wb_fire) begin
                        if (r_req.final_row) begin
                            r_sum <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
